>>> rtl/mpc_pkg.sv
// shared types, constants and fixed-point helpers for the mandelbrot pixel colour block
package mpc_pkg;

    // number format
    localparam int FRAC_BITS    = 28;
    localparam int WORD_W       = 32;
    localparam int PROD2_W      = 2 * WORD_W;
    localparam int COORD_W      = 11;
    localparam int DIFF_W       = COORD_W + 1;
    localparam int STEP_W       = 29;
    localparam int MAP_PROD_W   = DIFF_W + STEP_W + 1;
    localparam int SUM_W        = MAP_PROD_W + 1;
    localparam int THR_W        = 31;
    localparam int COUNT_W      = 12;
    localparam int COLOUR_W     = 24;
    localparam int PALETTE_SIZE = 16;
    localparam int ITER_MAX     = 4095;
    localparam int Q_DEPTH      = 2;

    localparam logic [WORD_W-1:0] WORD_MAX = {1'b0, {(WORD_W-1){1'b1}}};
    localparam logic [WORD_W-1:0] WORD_MIN = {1'b1, {(WORD_W-1){1'b0}}};

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_HALF_WIDTH       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HALF_HEIGHT      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PIXEL_STEP       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CENTRE_REAL      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CENTRE_IMAG      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ESCAPE_THRESHOLD = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_ITERATION_LIMIT  = 3'd6;

    // 16-word palette
    localparam logic [COLOUR_W-1:0] PALETTE [16] = '{
        24'h421E0F, 24'h19071A, 24'h09012F, 24'h040449,
        24'h000764, 24'h0C2C8A, 24'h1852B1, 24'h397DD1,
        24'h86B5E5, 24'hD3ECF8, 24'hF1E9BF, 24'hF8C95F,
        24'hFFAA00, 24'hCC8000, 24'h995700, 24'h6A3403
    };

    typedef struct packed {
        logic [COORD_W-1:0] pixel_col;
        logic [COORD_W-1:0] pixel_row;
    } pix_in_t;

    typedef struct packed {
        logic [COLOUR_W-1:0] colour_rgb;
        logic [COUNT_W-1:0]  escape_count;
        logic                inside_set;
    } pix_out_t;

    typedef struct packed {
        logic [COORD_W-1:0] half_width;
        logic [COORD_W-1:0] half_height;
        logic [STEP_W-1:0]  pixel_step;
        logic [WORD_W-1:0]  centre_real;
        logic [WORD_W-1:0]  centre_imag;
        logic [THR_W-1:0]   escape_threshold;
        logic [COUNT_W-1:0] iteration_limit;
    } cfg_t;

    // mapped point handed from front to back
    typedef struct packed {
        logic [WORD_W-1:0] re;
        logic [WORD_W-1:0] im;
    } point_t;

    typedef enum logic [1:0] {
        F_IDLE,
        F_MUL,
        F_ADD
    } front_state_t;

    typedef enum logic [1:0] {
        C_IDLE,
        C_ADD,
        C_MUL,
        C_DONE
    } core_state_t;

    // sign extend a word to the wide sum width
    function automatic logic [SUM_W-1:0] sext_word(input logic [WORD_W-1:0] x);
        return {{(SUM_W-WORD_W){x[WORD_W-1]}}, x};
    endfunction

    // clamp a wide two's complement sum to the word range
    function automatic logic [WORD_W-1:0] sat_word(input logic [SUM_W-1:0] x);
        if (!x[SUM_W-1] && (|x[SUM_W-2:WORD_W-1])) begin
            return WORD_MAX;
        end
        if (x[SUM_W-1] && !(&x[SUM_W-2:WORD_W-1])) begin
            return WORD_MIN;
        end
        return x[WORD_W-1:0];
    endfunction

    // palette lookup by count
    function automatic logic [COLOUR_W-1:0] palette_colour(input logic [COUNT_W-1:0] count);
        logic [COUNT_W-1:0] idx;
        idx = COUNT_W'(count % PALETTE_SIZE);
        return PALETTE[idx[3:0]];
    endfunction

endpackage

>>> rtl/mandelbrot_pixel_colour_top.sv
// top level: config registers, mapping front end, point queue and iteration core
// the iteration core takes a new pixel only when done with the last, looping through
// its add and multiply states; the mapping front end (idle, multiply and add states)
// overlaps with it, feeding mapped points into the queue
// reset: config registers take their defaults, queue empties, no transaction in flight
module mandelbrot_pixel_colour_top
    import mpc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  pix_in_t               in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output pix_out_t              out_data
);

    cfg_t   cfg_reg;
    logic   push_valid, push_ready, pop_valid, pop_ready;
    point_t push_data, pop_data;

    // configuration register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cfg_reg.half_width       <= COORD_W'(400);
            cfg_reg.half_height      <= COORD_W'(300);
            cfg_reg.pixel_step       <= STEP_W'(1789570);
            cfg_reg.centre_real      <= '0;
            cfg_reg.centre_imag      <= '0;
            cfg_reg.escape_threshold <= THR_W'(1073741824);
            cfg_reg.iteration_limit  <= COUNT_W'(255);
        end else if (cfg_we) begin
            case (cfg_index)
                REG_HALF_WIDTH:       cfg_reg.half_width       <= cfg_data[COORD_W-1:0];
                REG_HALF_HEIGHT:      cfg_reg.half_height      <= cfg_data[COORD_W-1:0];
                REG_PIXEL_STEP:       cfg_reg.pixel_step       <= cfg_data[STEP_W-1:0];
                REG_CENTRE_REAL:      cfg_reg.centre_real      <= cfg_data[WORD_W-1:0];
                REG_CENTRE_IMAG:      cfg_reg.centre_imag      <= cfg_data[WORD_W-1:0];
                REG_ESCAPE_THRESHOLD: cfg_reg.escape_threshold <= cfg_data[THR_W-1:0];
                REG_ITERATION_LIMIT:  cfg_reg.iteration_limit  <= cfg_data[COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    // pixel to point mapping
    mpc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_data    (in_data),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    // point queue
    mpc_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    // escape-time iteration and colouring
    mpc_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .q_valid   (pop_valid),
        .q_ready   (pop_ready),
        .q_data    (pop_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

>>> rtl/mpc_front.sv
// front end: accepts a pixel and maps it to a point of the complex plane
module mpc_front
    import mpc_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  cfg_t    cfg,
    input  logic    in_valid,
    output logic    in_ready,
    input  pix_in_t in_data,
    output logic    push_valid,
    input  logic    push_ready,
    output point_t  push_data
);

    front_state_t state_reg, state_next;

    logic signed [DIFF_W-1:0]     dre_reg, dim_reg;
    logic signed [MAP_PROD_W-1:0] pre_reg, pim_reg;
    logic signed [MAP_PROD_W-1:0] pre_next, pim_next;
    logic [SUM_W-1:0]             sum_re, sum_im;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            F_IDLE:  if (in_valid) state_next = F_MUL;
            F_MUL:   state_next = F_ADD;
            F_ADD:   if (push_ready) state_next = F_IDLE;
            default: state_next = F_IDLE;
        endcase
    end

    // handshake outputs
    always_comb
    begin
        in_ready   = 1'b0;
        push_valid = 1'b0;
        case (state_reg)
            F_IDLE:  in_ready = 1'b1;
            F_ADD:   push_valid = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= F_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // offset from centre pixel times step
    assign pre_next = MAP_PROD_W'(dre_reg) * MAP_PROD_W'($signed({1'b0, cfg.pixel_step}));
    assign pim_next = MAP_PROD_W'(dim_reg) * MAP_PROD_W'($signed({1'b0, cfg.pixel_step}));

    always_ff @(posedge clk)
    begin
        if (state_reg == F_IDLE && in_valid) begin
            dre_reg <= DIFF_W'({1'b0, in_data.pixel_col}) - DIFF_W'({1'b0, cfg.half_width});
            dim_reg <= DIFF_W'({1'b0, in_data.pixel_row}) - DIFF_W'({1'b0, cfg.half_height});
        end
        if (state_reg == F_MUL) begin
            pre_reg <= pre_next;
            pim_reg <= pim_next;
        end
    end

    // add centre and saturate
    assign sum_re = {pre_reg[MAP_PROD_W-1], pre_reg} + sext_word(cfg.centre_real);
    assign sum_im = {pim_reg[MAP_PROD_W-1], pim_reg} + sext_word(cfg.centre_imag);

    assign push_data.re = sat_word(sum_re);
    assign push_data.im = sat_word(sum_im);

endmodule

>>> rtl/mpc_fifo.sv
// short queue of mapped points between front end and iteration core
module mpc_fifo
    import mpc_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push_valid,
    output logic   push_ready,
    input  point_t push_data,
    output logic   pop_valid,
    input  logic   pop_ready,
    output point_t pop_data
);

    localparam int PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int CNT_W = $clog2(Q_DEPTH + 1);

    point_t             q_mem [Q_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               push, pop;

    assign push_ready = (count_reg != CNT_W'(Q_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_data   = q_mem[rd_ptr_reg];

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push) begin
            q_mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule

>>> rtl/mpc_core.sv
// iteration core: runs z = z*z + c for one point and holds the result register
module mpc_core
    import mpc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  cfg_t     cfg,
    input  logic     q_valid,
    output logic     q_ready,
    input  point_t   q_data,
    output logic     out_valid,
    input  logic     out_ready,
    output pix_out_t out_data
);

    core_state_t state_reg, state_next;

    logic [WORD_W-1:0]  re_reg, im_reg, u_reg, v_reg;
    logic [PROD2_W-1:0] uu_reg, vv_reg, uv_reg;
    logic               uv_neg_reg;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic               prev_reg;
    pix_out_t           res_reg, out_data_reg;
    logic               out_valid_reg;

    logic [WORD_W-1:0]  mag_u, mag_v;
    logic [WORD_W-1:0]  u2w, v2w, uvw, u_next, v_next;
    logic [WORD_W:0]    mag_sum;
    logic [COUNT_W-1:0] limit;
    logic               escaped, at_limit, slot_free;
    logic               load_item, do_mul, do_step, finish_esc, finish_in, load_out;

    // square: magnitude truncated, then clamped
    function automatic logic [WORD_W-1:0] sq_sat(input logic [PROD2_W-1:0] p);
        logic [PROD2_W-1:0] s;
        s = p >> FRAC_BITS;
        if (|s[PROD2_W-1:WORD_W-1]) begin
            return WORD_MAX;
        end
        return s[WORD_W-1:0];
    endfunction

    // doubled cross product in sign-magnitude form, clamped
    function automatic logic [WORD_W-1:0] cross_sat(input logic [PROD2_W-1:0] p,
                                                    input logic neg);
        logic [PROD2_W-1:0] s;
        s = p >> (FRAC_BITS - 1);
        if (neg) begin
            if ((|s[PROD2_W-1:WORD_W]) || (s[WORD_W-1] && (|s[WORD_W-2:0]))) begin
                return WORD_MIN;
            end
            return '0 - s[WORD_W-1:0];
        end
        if (|s[PROD2_W-1:WORD_W-1]) begin
            return WORD_MAX;
        end
        return s[WORD_W-1:0];
    endfunction

    // step arithmetic from registered products
    assign u2w     = sq_sat(uu_reg);
    assign v2w     = sq_sat(vv_reg);
    assign uvw     = cross_sat(uv_reg, uv_neg_reg);
    assign v_next  = sat_word(sext_word(uvw) + sext_word(im_reg));
    assign u_next  = sat_word(sext_word(u2w) - sext_word(v2w) + sext_word(re_reg));
    assign mag_sum = {1'b0, u2w} + {1'b0, v2w};
    assign escaped = prev_reg && (mag_sum >= (WORD_W+1)'(cfg.escape_threshold));

    // limit clamp and count check
    assign limit      = (cfg.iteration_limit > COUNT_W'(ITER_MAX)) ? COUNT_W'(ITER_MAX)
                                                                   : cfg.iteration_limit;
    assign count_next = prev_reg ? count_reg + 1'b1 : count_reg;
    assign at_limit   = (count_next >= limit);

    assign slot_free = !out_valid_reg || out_ready;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            C_IDLE:  if (q_valid) state_next = C_ADD;
            C_ADD:   state_next = (escaped || at_limit) ? C_DONE : C_MUL;
            C_MUL:   state_next = C_ADD;
            C_DONE:  if (slot_free) state_next = C_IDLE;
            default: state_next = C_IDLE;
        endcase
    end

    // control outputs
    always_comb
    begin
        q_ready    = 1'b0;
        load_item  = 1'b0;
        do_mul     = 1'b0;
        do_step    = 1'b0;
        finish_esc = 1'b0;
        finish_in  = 1'b0;
        load_out   = 1'b0;
        case (state_reg)
            C_IDLE: begin
                q_ready   = 1'b1;
                load_item = q_valid;
            end
            C_ADD: begin
                finish_esc = escaped;
                finish_in  = !escaped && at_limit;
                do_step    = !escaped && !at_limit;
            end
            C_MUL:   do_mul = 1'b1;
            C_DONE:  load_out = slot_free;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= C_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (load_out) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // operand magnitudes for the multipliers
    assign mag_u = u_reg[WORD_W-1] ? ('0 - u_reg) : u_reg;
    assign mag_v = v_reg[WORD_W-1] ? ('0 - v_reg) : v_reg;

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (load_item) begin
            re_reg     <= q_data.re;
            im_reg     <= q_data.im;
            u_reg      <= '0;
            v_reg      <= '0;
            uu_reg     <= '0;
            vv_reg     <= '0;
            uv_reg     <= '0;
            uv_neg_reg <= 1'b0;
            count_reg  <= COUNT_W'(1);
            prev_reg   <= 1'b0;
        end
        if (do_step) begin
            u_reg     <= u_next;
            v_reg     <= v_next;
            count_reg <= count_next;
            prev_reg  <= 1'b1;
        end
        if (do_mul) begin
            uu_reg     <= PROD2_W'(mag_u) * PROD2_W'(mag_u);
            vv_reg     <= PROD2_W'(mag_v) * PROD2_W'(mag_v);
            uv_reg     <= PROD2_W'(mag_u) * PROD2_W'(mag_v);
            uv_neg_reg <= u_reg[WORD_W-1] ^ v_reg[WORD_W-1];
        end
        if (finish_esc) begin
            res_reg.colour_rgb   <= palette_colour(count_reg);
            res_reg.escape_count <= count_reg;
            res_reg.inside_set   <= 1'b0;
        end
        if (finish_in) begin
            res_reg.colour_rgb   <= '0;
            res_reg.escape_count <= count_next;
            res_reg.inside_set   <= 1'b1;
        end
        if (load_out) begin
            out_data_reg <= res_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

`ifndef SYNTH
    a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_data_reg.escape_count != '0))
        else $error("result count is zero");

    a_inside_black: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_data_reg.inside_set) |-> (out_data_reg.colour_rgb == '0))
        else $error("inside pixel is not black");

    a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == C_DONE && slot_free) |=> out_valid_reg)
        else $error("finished result not presented");

    a_pop_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == C_IDLE && q_valid) |=> (state_reg == C_ADD))
        else $error("popped point did not start iterating");
`endif

endmodule

>>> tb/sv/tb_mandelbrot_pixel_colour_top.sv
// self-checking testbench for the mandelbrot pixel colour block
module tb_mandelbrot_pixel_colour_top;
    import mpc_pkg::*;

    // escape-time predictor and store of expected pixel results
    class pixel_colour_checker;
        localparam longint Q_HI = 64'sd2147483647;
        localparam longint Q_LO = -64'sd2147483648;

        cfg_t        view;
        pix_out_t    expected_pixels [$];
        pix_in_t     pixel_origin [$];
        int unsigned failures;

        function new();
            view.half_width       = 11'd400;
            view.half_height      = 11'd300;
            view.pixel_step       = 29'd1789570;
            view.centre_real      = '0;
            view.centre_imag      = '0;
            view.escape_threshold = 31'd1073741824;
            view.iteration_limit  = 12'd255;
            failures              = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                REG_HALF_WIDTH:       view.half_width       = val[COORD_W-1:0];
                REG_HALF_HEIGHT:      view.half_height      = val[COORD_W-1:0];
                REG_PIXEL_STEP:       view.pixel_step       = val[STEP_W-1:0];
                REG_CENTRE_REAL:      view.centre_real      = val[WORD_W-1:0];
                REG_CENTRE_IMAG:      view.centre_imag      = val[WORD_W-1:0];
                REG_ESCAPE_THRESHOLD: view.escape_threshold = val[THR_W-1:0];
                REG_ITERATION_LIMIT:  view.iteration_limit  = val[COUNT_W-1:0];
                default: ;
            endcase
        endfunction

        function longint clamp_word(longint x);
            if (x > Q_HI) return Q_HI;
            if (x < Q_LO) return Q_LO;
            return x;
        endfunction

        // sign-magnitude product, magnitude truncated before the sign is applied
        function longint fx_product(longint a, longint b, int unsigned sh);
            bit              neg;
            longint unsigned ma;
            longint unsigned mb;
            longint unsigned prod;
            neg  = (a < 0) != (b < 0);
            ma   = (a < 0) ? -a : a;
            mb   = (b < 0) ? -b : b;
            prod = (ma * mb) >> sh;
            return neg ? -longint'(prod) : longint'(prod);
        endfunction

        function pix_out_t predict_colour(pix_in_t p);
            pix_out_t res;
            longint   col, row, hw, hh, step, cr, ci, thr;
            longint   re, im, u, v, u2, v2;
            int       lim, k;
            bit       done;
            col  = longint'(p.pixel_col);
            row  = longint'(p.pixel_row);
            hw   = longint'(view.half_width);
            hh   = longint'(view.half_height);
            step = longint'(view.pixel_step);
            cr   = longint'($signed(view.centre_real));
            ci   = longint'($signed(view.centre_imag));
            thr  = longint'(view.escape_threshold);
            re   = clamp_word((col - hw) * step + cr);
            im   = clamp_word((row - hh) * step + ci);
            lim  = (int'(view.iteration_limit) > ITER_MAX) ? ITER_MAX
                                                          : int'(view.iteration_limit);
            u    = 0;
            v    = 0;
            u2   = 0;
            v2   = 0;
            k    = 1;
            done = 1'b0;
            // z = z*z + c until the squared magnitude reaches the threshold or k reaches the limit
            while (!done && k < lim) begin
                v  = clamp_word(fx_product(u, v, FRAC_BITS - 1) + im);
                u  = clamp_word(u2 - v2 + re);
                u2 = clamp_word(fx_product(u, u, FRAC_BITS));
                v2 = clamp_word(fx_product(v, v, FRAC_BITS));
                if (u2 + v2 >= thr) begin
                    done = 1'b1;
                end
                else begin
                    k++;
                end
            end
            res.inside_set   = (k >= lim);
            res.escape_count = k[COUNT_W-1:0];
            res.colour_rgb   = res.inside_set ? '0 : PALETTE[k % PALETTE_SIZE];
            return res;
        endfunction

        function void note_pixel(pix_in_t p);
            expected_pixels.push_back(predict_colour(p));
            pixel_origin.push_back(p);
        endfunction

        function void check_result(pix_out_t got);
            pix_out_t want;
            pix_in_t  p;
            if (expected_pixels.size() == 0) begin
                failures++;
                if (failures <= 10) begin
                    $display("unexpected result: rgb %06h count %0d inside %0b",
                             got.colour_rgb, got.escape_count, got.inside_set);
                end
                return;
            end
            want = expected_pixels.pop_front();
            p    = pixel_origin.pop_front();
            if (got.colour_rgb !== want.colour_rgb || got.escape_count !== want.escape_count
                || got.inside_set !== want.inside_set) begin
                failures++;
                if (failures <= 10) begin
                    $display("mismatch at pixel (%0d,%0d): expected rgb %06h count %0d inside %0b,",
                             p.pixel_col, p.pixel_row,
                             want.colour_rgb, want.escape_count, want.inside_set);
                    $display("    got rgb %06h count %0d inside %0b",
                             got.colour_rgb, got.escape_count, got.inside_set);
                end
            end
        endfunction

        function int pending();
            return expected_pixels.size();
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  in_valid;
    logic                  in_ready;
    pix_in_t               in_data;
    logic                  out_valid;
    logic                  out_ready;
    pix_out_t              out_data;

    pixel_colour_checker sb = new();
    pix_in_t             batch_q [$];
    int                  burst_left;
    bit                  hold_off_req;

    mandelbrot_pixel_colour_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    // clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // transaction monitor on both channels
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                sb.note_pixel(in_data);
            end
            if (out_valid && out_ready)
            begin
                sb.check_result(out_data);
            end
        end
    end

    // result side: stall patterns plus one long hold-off on request
    initial
    begin : receiver
        int mode;
        int mode_left;
        int hold_left;
        int tick;
        mode      = 0;
        mode_left = 0;
        hold_left = 0;
        tick      = 0;
        out_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_off_req)
            begin
                hold_left    = 500;
                hold_off_req = 1'b0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode      = $urandom_range(0, 3);
                    mode_left = $urandom_range(20, 300);
                end
                mode_left--;
                tick++;
                case (mode)
                    0:       out_ready <= 1'b1;
                    1:       out_ready <= 1'($urandom_range(0, 1));
                    2:       out_ready <= (tick % 4 == 0);
                    default: out_ready <= ($urandom_range(0, 7) != 0);
                endcase
            end
        end
    end

    // run limit
    initial
    begin
        #40_000_000;
        $display("[mandelbrot_pixel_colour_top] ERROR");
        $finish;
    end

    function automatic pix_in_t px(int col, int row);
        pix_in_t p;
        p.pixel_col = COORD_W'(col);
        p.pixel_row = COORD_W'(row);
        return p;
    endfunction

    // mostly near the view centre, sometimes anywhere on the screen
    function automatic int pick_coord(int centre_px);
        int c;
        if ($urandom_range(0, 7) == 0)
        begin
            return $urandom_range(0, 2047);
        end
        c = centre_px + int'($urandom_range(0, 128)) - 64;
        if (c < 0) c = 0;
        if (c > 2047) c = 2047;
        return c;
    endfunction

    function automatic cfg_t random_view();
        cfg_t        c;
        int unsigned sel;
        c.half_width  = COORD_W'($urandom_range(0, 2047));
        c.half_height = COORD_W'($urandom_range(0, 2047));
        sel = $urandom_range(0, 9);
        if (sel == 0)      c.pixel_step = STEP_W'($urandom);
        else if (sel == 1) c.pixel_step = '0;
        else               c.pixel_step = STEP_W'($urandom_range(1 << 14, 1 << 23));
        // centre mostly inside the interesting part of the plane
        sel = $urandom_range(0, 9);
        if (sel == 0)
        begin
            c.centre_real = $urandom;
            c.centre_imag = $urandom;
        end
        else
        begin
            c.centre_real = $urandom_range(0, 3 << 28) - (2 << 28);
            c.centre_imag = $urandom_range(0, 3 << 28) - (3 << 27);
        end
        sel = $urandom_range(0, 9);
        if (sel == 0)      c.escape_threshold = THR_W'($urandom);
        else if (sel == 1) c.escape_threshold = '0;
        else               c.escape_threshold = 31'd1 << 30;
        sel = $urandom_range(0, 19);
        if (sel == 0)      c.iteration_limit = COUNT_W'($urandom_range(0, 1));
        else if (sel == 1) c.iteration_limit = COUNT_W'($urandom_range(64, 300));
        else               c.iteration_limit = COUNT_W'($urandom_range(2, 48));
        return c;
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        sb.set_reg(idx, val);
    endtask

    task automatic apply_config(input cfg_t c);
        write_reg(REG_HALF_WIDTH,       CFG_DATA_W'(c.half_width));
        write_reg(REG_HALF_HEIGHT,      CFG_DATA_W'(c.half_height));
        write_reg(REG_PIXEL_STEP,       CFG_DATA_W'(c.pixel_step));
        write_reg(REG_CENTRE_REAL,      CFG_DATA_W'(c.centre_real));
        write_reg(REG_CENTRE_IMAG,      CFG_DATA_W'(c.centre_imag));
        write_reg(REG_ESCAPE_THRESHOLD, CFG_DATA_W'(c.escape_threshold));
        write_reg(REG_ITERATION_LIMIT,  CFG_DATA_W'(c.iteration_limit));
        cfg_we <= 1'b0;
    endtask

    // offer one pixel in bursts with random gaps, hold until the transaction
    task automatic offer_pixel(input pix_in_t p);
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            if ($urandom_range(0, 2) != 0)
            begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        in_data  <= p;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    // wait until every predicted pixel has come back and the block is quiet
    task automatic drain_block();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0) @(posedge clk);
        repeat (12) @(posedge clk);
    endtask

    task automatic run_phase(input cfg_t c);
        apply_config(c);
        foreach (batch_q[i])
        begin
            offer_pixel(batch_q[i]);
        end
        drain_block();
    endtask

    initial
    begin : stimulus
        cfg_t c;
        int   sent;
        int   phase;
        int   batch;
        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        in_valid     = 1'b0;
        in_data      = '0;
        burst_left   = 0;
        hold_off_req = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // default view: screen corners, centre and points on the real axis
        c = sb.view;
        batch_q = '{px(400, 300), px(0, 0), px(2047, 2047), px(2047, 0), px(0, 2047),
                    px(300, 300), px(500, 300)};
        run_phase(c);

        // limit of zero and of one: no iteration, always inside
        c.iteration_limit = 12'd0;
        batch_q = '{px(400, 300), px(123, 456)};
        run_phase(c);
        c.iteration_limit = 12'd1;
        batch_q = '{px(0, 0)};
        run_phase(c);

        // zero threshold escapes on the first pass
        c.half_width       = 11'd1024;
        c.half_height      = 11'd1024;
        c.pixel_step       = 29'd1 << 28;
        c.escape_threshold = '0;
        c.iteration_limit  = 12'd2;
        batch_q = '{px(1024, 1024), px(2047, 2047)};
        run_phase(c);

        // zero step maps everything to the centre, full iteration count
        c.pixel_step       = '0;
        c.centre_real      = -(32'sd1 << 28);
        c.centre_imag      = '0;
        c.escape_threshold = 31'd1 << 30;
        c.iteration_limit  = 12'd4095;
        batch_q = '{px(0, 0), px(2047, 2047)};
        run_phase(c);

        // mapping saturates and squares overflow
        c.half_width       = 11'd0;
        c.half_height      = 11'd2047;
        c.pixel_step       = {STEP_W{1'b1}};
        c.centre_real      = WORD_MAX;
        c.centre_imag      = WORD_MIN;
        c.escape_threshold = {THR_W{1'b1}};
        batch_q = '{px(2047, 0), px(0, 2047), px(0, 0), px(2047, 2047)};
        run_phase(c);

        // opposite corner of the register space
        c.half_width       = 11'd2047;
        c.half_height      = 11'd0;
        c.pixel_step       = 29'd1 << 28;
        c.centre_real      = WORD_MIN;
        c.centre_imag      = WORD_MAX;
        c.escape_threshold = 31'd1 << 30;
        batch_q = '{px(0, 0), px(2047, 0)};
        run_phase(c);

        // random views, one of them under a long receiver hold-off
        sent  = 0;
        phase = 0;
        while (sent < 1600)
        begin
            c = random_view();
            batch = (c.iteration_limit > 64) ? $urandom_range(8, 20) : $urandom_range(30, 120);
            batch_q.delete();
            repeat (batch)
            begin
                batch_q.push_back(px(pick_coord(int'(c.half_width)),
                                     pick_coord(int'(c.half_height))));
            end
            if (phase == 1)
            begin
                hold_off_req = 1'b1;
            end
            run_phase(c);
            sent += batch;
            phase++;
        end

        repeat (20) @(posedge clk);
        if (sb.failures == 0 && sb.pending() == 0)
        begin
            $display("[mandelbrot_pixel_colour_top] OK");
        end
        else
        begin
            $display("[mandelbrot_pixel_colour_top] ERROR");
        end
        $finish;
    end

endmodule
